### rtl/lqrbw_pkg.sv
// Package for the balancing wheel command block: field widths, limits,
// micro-operation codes and the microcode table. No dependencies.
`default_nettype none

package lqrbw_pkg;

    // Field widths
    localparam int PITCH_W      = 19;
    localparam int RATE_W       = 23;
    localparam int VEL_W        = 21;
    localparam int YAW_RATE_W   = 22;
    localparam int DT_W         = 13;
    localparam int BODY_W       = 32;
    localparam int WHEEL_W      = 24;
    localparam int GAIN_W       = 27;
    localparam int FACTOR_W     = 23;
    localparam int INTEGRAL_W   = 15;

    // Configuration port
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 27;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PITCH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_OMEGA      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_VELOCITY   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEGRAL   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_OFFSET    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_LIMIT     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LINEAR_TO_WHEEL = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_YAW_TO_WHEEL    = 3'd7;

    // Shared multiplier: 32 x 28 signed, product registered
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 28;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_W   = 16;
    localparam int SHIFT_W  = PROD_W - FRAC_W;

    // Q16.16 constants: 0.05 and 0.2
    localparam int DELTA_LIMIT    = 3277;
    localparam int INTEGRAL_LIMIT = 13107;

    // Microprogram
    localparam int STEP_W   = 4;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VEL_DT,
        MUL_KP,
        MUL_KR,
        MUL_KV,
        MUL_KI,
        MUL_LIN,
        MUL_YAW
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        U_NONE,
        U_TARGET,
        U_CLEAR,
        U_INTEG,
        U_BODY,
        U_WHEELS
    } unit_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_SKIP_IF_CALM,
        SEQ_END
    } seq_op_t;

    typedef struct packed {
        mul_op_t  mul_op;
        acc_op_t  acc_op;
        unit_op_t unit_op;
        seq_op_t  seq_op;
        step_t    jump;
    } ucode_t;

    localparam ucode_t UCODE_NOP = '{MUL_NONE, ACC_HOLD, U_NONE, SEQ_NEXT, step_t'(0)};

    // Control store. The product of a step is ready in the step after it.
    function automatic ucode_t microcode(input step_t step);
        ucode_t word;
        word = UCODE_NOP;
        unique case (step)
            // error times dt, record target, skip the clear on a small change
            4'd0:  word = '{MUL_VEL_DT, ACC_HOLD, U_TARGET, SEQ_SKIP_IF_CALM, step_t'(2)};
            4'd1:  word = '{MUL_NONE,   ACC_HOLD, U_CLEAR,  SEQ_NEXT, step_t'(0)};
            4'd2:  word = '{MUL_KP,     ACC_HOLD, U_INTEG,  SEQ_NEXT, step_t'(0)};
            4'd3:  word = '{MUL_KR,     ACC_LOAD, U_NONE,   SEQ_NEXT, step_t'(0)};
            4'd4:  word = '{MUL_KV,     ACC_ADD,  U_NONE,   SEQ_NEXT, step_t'(0)};
            4'd5:  word = '{MUL_KI,     ACC_ADD,  U_NONE,   SEQ_NEXT, step_t'(0)};
            4'd6:  word = '{MUL_NONE,   ACC_ADD,  U_NONE,   SEQ_NEXT, step_t'(0)};
            4'd7:  word = '{MUL_NONE,   ACC_HOLD, U_BODY,   SEQ_NEXT, step_t'(0)};
            4'd8:  word = '{MUL_LIN,    ACC_HOLD, U_NONE,   SEQ_NEXT, step_t'(0)};
            4'd9:  word = '{MUL_YAW,    ACC_LOAD, U_NONE,   SEQ_NEXT, step_t'(0)};
            4'd10: word = '{MUL_NONE,   ACC_HOLD, U_WHEELS, SEQ_END,  step_t'(0)};
            default: word = UCODE_NOP;
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

### rtl/lqrbw_tick_if.sv
// Input channel for one control tick: valid/ready handshake and sensor fields.
// Depends on lqrbw_pkg for field widths.
`default_nettype none

interface lqrbw_tick_if;
    import lqrbw_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [PITCH_W-1:0]     pitch;
    logic signed [RATE_W-1:0]      pitch_omega;
    logic signed [VEL_W-1:0]       measured_velocity;
    logic signed [VEL_W-1:0]       target_velocity;
    logic signed [YAW_RATE_W-1:0]  yaw_demand;
    logic        [DT_W-1:0]        time_step;

    modport source (
        output valid, pitch, pitch_omega, measured_velocity, target_velocity,
               yaw_demand, time_step,
        input  ready
    );

    modport sink (
        input  valid, pitch, pitch_omega, measured_velocity, target_velocity,
               yaw_demand, time_step,
        output ready
    );
endinterface

`default_nettype wire

### rtl/lqrbw_cmd_if.sv
// Output channel for one command beat: valid/ready handshake and commands.
// Depends on lqrbw_pkg for field widths.
`default_nettype none

interface lqrbw_cmd_if;
    import lqrbw_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [BODY_W-1:0]   body_velocity_cmd;
    logic signed [WHEEL_W-1:0]  left_wheel_cmd;
    logic signed [WHEEL_W-1:0]  right_wheel_cmd;

    modport source (
        output valid, body_velocity_cmd, left_wheel_cmd, right_wheel_cmd,
        input  ready
    );

    modport sink (
        input  valid, body_velocity_cmd, left_wheel_cmd, right_wheel_cmd,
        output ready
    );
endinterface

`default_nettype wire

### rtl/lqrbw_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on lqrbw_pkg for the control word and the microprogram.
`default_nettype none

module lqrbw_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              calm,
    input  logic              hold,
    output lqrbw_pkg::ucode_t ctrl,
    output logic              busy
);
    import lqrbw_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    logic   busy_reg;
    logic   busy_next;
    ucode_t word;

    assign word = microcode(step_reg);

    // Advance, jump or finish the program
    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else
        begin
            unique case (word.seq_op)
                SEQ_NEXT:
                    step_next = step_reg + 1'b1;
                SEQ_SKIP_IF_CALM:
                    step_next = calm ? word.jump : step_reg + 1'b1;
                SEQ_END:
                    if (!hold)
                    begin
                        busy_next = 1'b0;
                    end
                default:
                    busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    // Issue no-ops while idle
    assign ctrl = busy_reg ? word : UCODE_NOP;
    assign busy = busy_reg;

endmodule

`default_nettype wire

### rtl/lqr_balance_wheel_command_core.sv
// Balancing wheel command core: a microprogram on one shared 32x28 multiplier.
// The result beat is loaded into the output register on the final step; a large
// target move adds a step that clears the integral. A new tick is taken only
// once the program has finished, and the final step is held while the previous
// beat waits in the output register. Reset clears the integral, the previous
// target and the handshakes and loads the register defaults (lin factor 1.0).
`default_nettype none

module lqr_balance_wheel_command_core (
    input  logic                                clk,
    input  logic                                rst_n,
    lqrbw_tick_if.sink                          tick,
    lqrbw_cmd_if.source                         cmd,
    input  logic                                cfg_wr_en,
    input  logic [lqrbw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lqrbw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lqrbw_pkg::*;

    localparam logic signed [SHIFT_W-1:0] BODY_MAX = SHIFT_W'(64'sd2147483647);
    localparam logic signed [SHIFT_W-1:0] BODY_MIN = SHIFT_W'(-64'sd2147483648);
    localparam logic signed [VEL_W:0]     DELTA_HI = (VEL_W+1)'(DELTA_LIMIT);
    localparam logic signed [VEL_W:0]     DELTA_LO = (VEL_W+1)'(-DELTA_LIMIT);
    localparam int                        ISUM_W   = VEL_W;
    localparam logic signed [ISUM_W-1:0]  INT_HI   = ISUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [ISUM_W-1:0]  INT_LO   = ISUM_W'(-INTEGRAL_LIMIT);

    // Configuration registers
    logic signed [GAIN_W-1:0]   gain_pitch_reg;
    logic signed [GAIN_W-1:0]   gain_omega_reg;
    logic signed [GAIN_W-1:0]   gain_velocity_reg;
    logic signed [GAIN_W-1:0]   gain_integral_reg;
    logic signed [PITCH_W-1:0]  pitch_offset_reg;
    logic        [FACTOR_W-1:0] wheel_limit_reg;
    logic        [FACTOR_W-1:0] linear_to_wheel_reg;
    logic        [FACTOR_W-1:0] yaw_to_wheel_reg;

    // Latched tick
    logic signed [PITCH_W-1:0]    pitch_reg;
    logic signed [RATE_W-1:0]     pitch_omega_reg;
    logic signed [VEL_W-1:0]      measured_reg;
    logic signed [VEL_W-1:0]      target_reg;
    logic signed [YAW_RATE_W-1:0] yaw_rate_reg;
    logic        [DT_W-1:0]       dt_reg;

    // Controller state and datapath
    logic signed [VEL_W-1:0]      prev_target_reg;
    logic signed [VEL_W-1:0]      prev_target_next;
    logic signed [INTEGRAL_W-1:0] integral_reg;
    logic signed [INTEGRAL_W-1:0] integral_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     acc_reg;
    logic signed [PROD_W-1:0]     acc_next;
    logic signed [BODY_W-1:0]     body_reg;
    logic signed [BODY_W-1:0]     body_next;

    // Output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [BODY_W-1:0]     out_body_reg;
    logic signed [WHEEL_W-1:0]    out_left_reg;
    logic signed [WHEEL_W-1:0]    out_right_reg;

    logic                         accept;
    logic                         busy;
    logic                         calm;
    logic                         out_hold;
    logic                         emit;
    ucode_t                       ctrl;

    logic signed [PITCH_W:0]      pitch_err;
    logic signed [VEL_W:0]        vel_err;
    logic signed [VEL_W:0]        delta;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [ISUM_W-1:0]     integ_sum;
    logic signed [PROD_W-1:0]     body_neg;
    logic signed [SHIFT_W-1:0]    body_shift;
    logic signed [PROD_W-1:0]     wheel_diff;
    logic signed [PROD_W-1:0]     wheel_sum;
    logic signed [SHIFT_W-1:0]    wheel_lim;
    logic signed [WHEEL_W-1:0]    left_cmd;
    logic signed [WHEEL_W-1:0]    right_cmd;

    // Clamp a shifted wheel value to the symmetric limit
    function automatic logic signed [WHEEL_W-1:0] wheel_clamp(
        input logic signed [SHIFT_W-1:0] v,
        input logic signed [SHIFT_W-1:0] lim
    );
        logic signed [SHIFT_W-1:0] r;
        r = v;
        if (v < -lim)
        begin
            r = -lim;
        end
        else if (v > lim)
        begin
            r = lim;
        end
        return r[WHEEL_W-1:0];
    endfunction

    lqrbw_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .calm  (calm),
        .hold  (out_hold),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    assign tick.ready = !busy;
    assign accept     = tick.valid && !busy;
    assign out_hold   = out_valid_reg && !cmd.ready;
    assign emit       = (ctrl.unit_op == U_WHEELS) && !out_hold;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_pitch_reg      <= '0;
            gain_omega_reg      <= '0;
            gain_velocity_reg   <= '0;
            gain_integral_reg   <= '0;
            pitch_offset_reg    <= '0;
            wheel_limit_reg     <= '0;
            linear_to_wheel_reg <= FACTOR_W'(65536);
            yaw_to_wheel_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_PITCH:      gain_pitch_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_OMEGA:      gain_omega_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_VELOCITY:   gain_velocity_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEGRAL:   gain_integral_reg   <= cfg_data[GAIN_W-1:0];
                REG_PITCH_OFFSET:    pitch_offset_reg    <= cfg_data[PITCH_W-1:0];
                REG_WHEEL_LIMIT:     wheel_limit_reg     <= cfg_data[FACTOR_W-1:0];
                REG_LINEAR_TO_WHEEL: linear_to_wheel_reg <= cfg_data[FACTOR_W-1:0];
                REG_YAW_TO_WHEEL:    yaw_to_wheel_reg    <= cfg_data[FACTOR_W-1:0];
                default:             ;
            endcase
        end
    end

    // Capture the tick beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pitch_reg       <= tick.pitch;
            pitch_omega_reg <= tick.pitch_omega;
            measured_reg    <= tick.measured_velocity;
            target_reg      <= tick.target_velocity;
            yaw_rate_reg    <= tick.yaw_demand;
            dt_reg          <= tick.time_step;
        end
    end

    // Error terms and target step test
    assign pitch_err = (PITCH_W+1)'(pitch_reg) - (PITCH_W+1)'(pitch_offset_reg);
    assign vel_err   = (VEL_W+1)'(target_reg) - (VEL_W+1)'(measured_reg);
    assign delta     = (VEL_W+1)'(target_reg) - (VEL_W+1)'(prev_target_reg);
    assign calm      = (delta <= DELTA_HI) && (delta >= DELTA_LO);

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul_op)
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_VEL_DT:
            begin
                mul_a = MUL_A_W'(vel_err);
                mul_b = $signed(MUL_B_W'(dt_reg));
            end
            MUL_KP:
            begin
                mul_a = MUL_A_W'(pitch_err);
                mul_b = MUL_B_W'(gain_pitch_reg);
            end
            MUL_KR:
            begin
                mul_a = MUL_A_W'(pitch_omega_reg);
                mul_b = MUL_B_W'(gain_omega_reg);
            end
            MUL_KV:
            begin
                mul_a = MUL_A_W'(vel_err);
                mul_b = MUL_B_W'(gain_velocity_reg);
            end
            MUL_KI:
            begin
                mul_a = MUL_A_W'(integral_reg);
                mul_b = MUL_B_W'(gain_integral_reg);
            end
            MUL_LIN:
            begin
                mul_a = body_reg;
                mul_b = $signed(MUL_B_W'(linear_to_wheel_reg));
            end
            MUL_YAW:
            begin
                mul_a = MUL_A_W'(yaw_rate_reg);
                mul_b = $signed(MUL_B_W'(yaw_to_wheel_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Multiply and accumulate
    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.mul_op != MUL_NONE)
        begin
            prod_next = PROD_W'(mul_a * mul_b);
        end
        acc_next = acc_reg;
        unique case (ctrl.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    // Integral update: floor shift of error*dt, add, clamp to +-0.2
    assign integ_sum = ISUM_W'(integral_reg) + prod_reg[FRAC_W +: ISUM_W];

    // Body command: negate, floor shift, saturate to 32 bits
    assign body_neg   = -acc_reg;
    assign body_shift = body_neg[PROD_W-1:FRAC_W];

    // Wheels: base -+ spin, floor shift, clamp to the wheel limit
    assign wheel_diff = acc_reg - prod_reg;
    assign wheel_sum  = acc_reg + prod_reg;
    assign wheel_lim  = $signed(SHIFT_W'(wheel_limit_reg));
    assign left_cmd   = wheel_clamp(wheel_diff[PROD_W-1:FRAC_W], wheel_lim);
    assign right_cmd  = wheel_clamp(wheel_sum[PROD_W-1:FRAC_W], wheel_lim);

    always_comb
    begin
        prev_target_next = prev_target_reg;
        integral_next    = integral_reg;
        body_next        = body_reg;
        unique case (ctrl.unit_op)
            U_NONE:
                ;
            U_TARGET:
                prev_target_next = target_reg;
            U_CLEAR:
                integral_next = '0;
            U_INTEG:
            begin
                if (integ_sum > INT_HI)
                begin
                    integral_next = INTEGRAL_W'(INT_HI);
                end
                else if (integ_sum < INT_LO)
                begin
                    integral_next = INTEGRAL_W'(INT_LO);
                end
                else
                begin
                    integral_next = integ_sum[INTEGRAL_W-1:0];
                end
            end
            U_BODY:
            begin
                if (body_shift > BODY_MAX)
                begin
                    body_next = BODY_MAX[BODY_W-1:0];
                end
                else if (body_shift < BODY_MIN)
                begin
                    body_next = BODY_MIN[BODY_W-1:0];
                end
                else
                begin
                    body_next = body_shift[BODY_W-1:0];
                end
            end
            U_WHEELS:
                ;
            default:
                ;
        endcase
    end

    // Hold the beat until taken; load a new one on the last step
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmd.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_target_reg <= '0;
            integral_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_target_reg <= prev_target_next;
            integral_reg    <= integral_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        body_reg <= body_next;
        if (emit)
        begin
            out_body_reg  <= body_reg;
            out_left_reg  <= left_cmd;
            out_right_reg <= right_cmd;
        end
    end

    assign cmd.valid             = out_valid_reg;
    assign cmd.body_velocity_cmd = out_body_reg;
    assign cmd.left_wheel_cmd    = out_left_reg;
    assign cmd.right_wheel_cmd   = out_right_reg;

`ifndef SYNTHESIS
    a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= INTEGRAL_W'(INTEGRAL_LIMIT))
            && (integral_reg >= INTEGRAL_W'(-INTEGRAL_LIMIT)))
        else $error("velocity integral outside its clamp");

    a_beat_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.valid) |-> $past(ctrl.unit_op == U_WHEELS))
        else $error("result beat raised outside the final step");

    a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> (busy && ctrl.unit_op == U_TARGET))
        else $error("accepted tick did not start the program");

    a_stall_keeps_program: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.unit_op == U_WHEELS && cmd.valid && !cmd.ready)
            |=> (busy && ctrl.unit_op == U_WHEELS))
        else $error("final step left while the output beat was stalled");
`endif

endmodule

`default_nettype wire
